>>> hdl/mcl_pkg.sv
// package for the month calendar layout block
// widths, codes, the month tables and the grid command struct; no dependencies
`default_nettype none

package mcl_pkg;

  // field widths
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned COL_W       = 3;
  localparam int unsigned ROW_W       = 3;
  localparam int unsigned CHAR_W      = 6;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // shared divider geometry
  localparam int unsigned DIVIDEND_W = YEAR_W;
  localparam int unsigned DIVISOR_W  = 7;

  // reciprocal multiply: quotient = (dividend * RECIP) >> RECIP_SHIFT,
  // exact for every dividend below 2**14 with either divisor
  localparam int unsigned          RECIP_W       = 17;
  localparam int unsigned          RECIP_SHIFT   = 19;
  localparam logic [RECIP_W-1:0]   RECIP_HUNDRED = RECIP_W'(5243);
  localparam logic [RECIP_W-1:0]   RECIP_WEEK    = RECIP_W'(74899);

  // constants
  localparam logic [YEAR_W-1:0]    YEAR_MAX     = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0]   MONTH_JAN    = MONTH_W'(1);
  localparam logic [MONTH_W-1:0]   MONTH_FEB    = MONTH_W'(2);
  localparam logic [MONTH_W-1:0]   MONTH_DEC    = MONTH_W'(12);
  localparam logic [MONTH_W-1:0]   MONTHS_YEAR  = MONTH_W'(12);
  localparam logic [DIVISOR_W-1:0] DVS_HUNDRED  = DIVISOR_W'(100);
  localparam logic [DIVISOR_W-1:0] DVS_WEEK     = DIVISOR_W'(7);
  localparam logic [DIVISOR_W-1:0] REM_99       = DIVISOR_W'(99);
  localparam logic [COL_W-1:0]     COL_SATURDAY = COL_W'(6);
  localparam logic [CHAR_W-1:0]    ASCII_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]    ASCII_SPACE  = CHAR_W'(32);
  localparam logic [3:0]           UNITS_NINE   = 4'd9;

  // command from the sequencer to the day walker
  typedef struct packed {
    logic             start;
    logic [DAY_W-1:0] len;
    logic [COL_W-1:0] first_col;
  } mcl_grid_cmd_t;

  // number of days in a month, leap selects 29 for february
  function automatic logic [DAY_W-1:0] mcl_month_len(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd2:                      len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
      default:                   len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // (13*m + 8)/5 for the shifted month 3..14
  function automatic logic [5:0] mcl_month_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    unique case (m)
      4'd3:    t = 6'd9;
      4'd4:    t = 6'd12;
      4'd5:    t = 6'd14;
      4'd6:    t = 6'd17;
      4'd7:    t = 6'd19;
      4'd8:    t = 6'd22;
      4'd9:    t = 6'd25;
      4'd10:   t = 6'd27;
      4'd11:   t = 6'd30;
      4'd12:   t = 6'd32;
      4'd13:   t = 6'd35;
      4'd14:   t = 6'd38;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hdl/month_calendar_layout.sv
// Month calendar layout: takes a year (1..9999) and a month (1..12) and emits one
// item per day with the day number, weekday column (Sunday 0), week row and two
// ASCII digits; tlast marks the final day. An out-of-range year or month is
// taken and gives no items, and the block is ready again on the next cycle. The
// block works on one month at a time and is not ready until the last day has
// been taken. After a year/month item is taken, the sequencer passes a start
// state, then makes two passes through the shared reciprocal-multiply divider
// (shifted year by 100 for the century terms and the leap rule, then the
// congruence sum by 7 for the first weekday) and then loads the day walker,
// which gives one day item per cycle while the sink is ready and stalls while
// the sink holds tready low.
// depends on mcl_pkg, mcl_div and mcl_grid
`default_nettype none

module month_calendar_layout (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // year[13:0], month[17:14]
  input  logic [mcl_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // day_number[4:0], column[7:5], row[10:8], tens_char[16:11], units_char[22:17]
  output logic [mcl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // last_day
  output logic                             m_axis_tlast_o
);

  import mcl_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_START100 = 3'd1;
  localparam logic [2:0] ST_DIV100   = 3'd2;
  localparam logic [2:0] ST_MOD7     = 3'd3;
  localparam logic [2:0] ST_EMIT     = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [YEAR_W-1:0]     year_in;
  logic [MONTH_W-1:0]    month_in;
  logic                  in_take;
  logic                  in_ok;
  logic                  early;
  logic [YEAR_W-1:0]     ya_q;
  logic [MONTH_W-1:0]    ma_q;
  logic [MONTH_W-1:0]    month_q;
  logic [1:0]            ylow_q;
  logic                  early_q;
  logic                  leap_q;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic                  div_week;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quot;
  logic [DIVISOR_W-1:0]  div_rem;
  logic [YEAR_W-1:0]     zsum;
  logic                  hundred_zero;
  logic                  four_hundred;
  logic                  leap;
  logic                  grid_done;
  mcl_grid_cmd_t         grid_cmd;

  assign year_in  = s_axis_tdata_i[YEAR_W-1:0];
  assign month_in = s_axis_tdata_i[YEAR_W +: MONTH_W];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_ok    = (year_in != '0) && (year_in <= YEAR_MAX) &&
                    (month_in != '0) && (month_in <= MONTH_DEC);
  assign early    = (month_in <= MONTH_FEB);

  // congruence sum from the shifted year and its quotient by 100, below 2**14
  assign zsum = ya_q + (ya_q >> 2) - div_quot + (div_quot >> 2)
              + YEAR_W'(mcl_month_term(ma_q)) + YEAR_W'(1);

  // leap rule of the true year from the shifted year's quotient and remainder
  always_comb begin
    if (early_q) begin
      hundred_zero = (div_rem == REM_99);
      four_hundred = hundred_zero && (div_quot[1:0] == 2'b11);
    end else begin
      hundred_zero = (div_rem == '0);
      four_hundred = hundred_zero && (div_quot[1:0] == 2'b00);
    end
    leap = ((ylow_q == 2'b00) && !hundred_zero) || four_hundred;
  end

  // sequencer
  always_comb begin
    state_d            = state_q;
    div_start          = 1'b0;
    div_dividend       = ya_q;
    div_week           = 1'b0;
    grid_cmd.start     = 1'b0;
    grid_cmd.len       = mcl_month_len(month_q, leap_q);
    grid_cmd.first_col = div_rem[COL_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_take && in_ok) state_d = ST_START100;
      end
      ST_START100: begin
        div_start = 1'b1;
        state_d   = ST_DIV100;
      end
      ST_DIV100: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = zsum;
          div_week     = 1'b1;
          state_d      = ST_MOD7;
        end
      end
      ST_MOD7: begin
        if (div_done) begin
          grid_cmd.start = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (grid_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // captured operands: jan and feb count as months 13 and 14 of the year before
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      month_q <= month_in;
      ylow_q  <= year_in[1:0];
      early_q <= early;
      ya_q    <= early ? (year_in - YEAR_W'(1)) : year_in;
      ma_q    <= early ? (month_in + MONTHS_YEAR) : month_in;
    end
    if ((state_q == ST_DIV100) && div_done) begin
      leap_q <= leap;
    end
  end

  mcl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .week_i     (div_week),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  mcl_grid u_grid (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (grid_cmd),
    .done_o          (grid_done),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

>>> hdl/mcl_div.sv
// shared divide-by-constant unit: reciprocal multiply for the quotient, then
// multiply back and subtract for the remainder; depends on mcl_pkg
`default_nettype none

module mcl_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           week_i,
  input  logic [mcl_pkg::DIVIDEND_W-1:0] dividend_i,
  output logic                           done_o,
  output logic [mcl_pkg::DIVIDEND_W-1:0] quot_o,
  output logic [mcl_pkg::DIVISOR_W-1:0]  rem_o
);

  import mcl_pkg::*;

  localparam int unsigned PROD_W = DIVIDEND_W + RECIP_W;

  logic                  mul_q;
  logic                  sub_q;
  logic                  done_q;
  logic                  week_q;
  logic [DIVIDEND_W-1:0] dvd_q;
  logic [DIVIDEND_W-1:0] quot_q, quot_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [RECIP_W-1:0]    recip;
  logic [DIVISOR_W-1:0]  dvs;
  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] back;

  // divide by 7 or by 100
  assign recip = week_q ? RECIP_WEEK : RECIP_HUNDRED;
  assign dvs   = week_q ? DVS_WEEK : DVS_HUNDRED;

  // quotient by reciprocal, remainder by multiplying back
  always_comb begin
    prod   = {{RECIP_W{1'b0}}, dvd_q} * {{DIVIDEND_W{1'b0}}, recip};
    quot_d = DIVIDEND_W'(prod >> RECIP_SHIFT);
    back   = quot_q * {{(DIVIDEND_W - DIVISOR_W){1'b0}}, dvs};
    rem_d  = DIVISOR_W'(dvd_q - back);
  end

  // stage flags: operands loaded, quotient ready, remainder ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  // operand, quotient and remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      week_q <= week_i;
    end
    if (mul_q) begin
      quot_q <= quot_d;
    end
    if (sub_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> hdl/mcl_grid.sv
// day walker: steps through the days of the month and drives the output items
// depends on mcl_pkg for widths, characters and the command struct
`default_nettype none

module mcl_grid (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mcl_pkg::mcl_grid_cmd_t              cmd_i,
  output logic                                done_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // day_number[4:0], column[7:5], row[10:8], tens_char[16:11], units_char[22:17]
  output logic [mcl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // last_day
  output logic                                m_axis_tlast_o
);

  import mcl_pkg::*;

  logic             valid_q;
  logic [DAY_W-1:0] day_q;
  logic [DAY_W-1:0] len_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [1:0]       tens_q;
  logic [3:0]       units_q;
  logic             take;
  logic             last;
  logic [CHAR_W-1:0] tens_char;
  logic [CHAR_W-1:0] units_char;

  assign take = valid_q && m_axis_tready_i;
  assign last = (day_q == len_q);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.start) begin
      valid_q <= 1'b1;
    end else if (take && last) begin
      valid_q <= 1'b0;
    end
  end

  // day, grid position and decimal digits advance on each taken item
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      day_q   <= DAY_W'(1);
      len_q   <= cmd_i.len;
      col_q   <= cmd_i.first_col;
      row_q   <= '0;
      tens_q  <= '0;
      units_q <= 4'd1;
    end else if (take) begin
      day_q <= day_q + DAY_W'(1);
      if (units_q == UNITS_NINE) begin
        units_q <= '0;
        tens_q  <= tens_q + 2'd1;
      end else begin
        units_q <= units_q + 4'd1;
      end
      if (col_q == COL_SATURDAY) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // ascii digits
  assign tens_char  = (tens_q == 2'd0) ? ASCII_SPACE : (ASCII_ZERO + CHAR_W'(tens_q));
  assign units_char = ASCII_ZERO + CHAR_W'(units_q);

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {1'b0, units_char, tens_char, row_q, col_q, day_q};
  assign m_axis_tlast_o  = last;
  assign done_o          = take && last;

endmodule

`default_nettype wire

>>> verif/tb_month_calendar_layout.sv
// testbench for month_calendar_layout: drives year/month items, predicts every day item
// of the grid and checks it field by field; depends on mcl_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_month_calendar_layout;
  import mcl_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned RANDOM_MONTHS  = 385;
  localparam int unsigned MAX_PRINTS     = 40;

  // one grid cell as the block should emit it
  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] tens;
    logic [CHAR_W-1:0] units;
    logic              last;
  } day_cell_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data = '0;
  logic                   m_ready = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;

  day_cell_t   pending_days[$];
  day_cell_t   got_cell;
  day_cell_t   want_cell;
  int unsigned src_gap_max = 0;
  int unsigned sink_stall_max = 0;
  int unsigned sink_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned day_errs = 0;
  int unsigned months_sent = 0;
  int unsigned months_void = 0;
  int unsigned days_checked = 0;

  month_calendar_layout u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // expected grid of one month, first weekday from the zeller-style congruence
  function automatic void predict_month(input logic [YEAR_W-1:0] year,
                                        input logic [MONTH_W-1:0] month);
    int unsigned yy, mm, len, col, row, sum;
    logic        leap;
    day_cell_t   one_day;
    if (year < 1 || year > YEAR_MAX || month < MONTH_JAN || month > MONTH_DEC) begin
      months_void++;
      return;
    end
    leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    case (month)
      MONTH_FEB:       len = leap ? 29 : 28;
      4, 6, 9, 11:     len = 30;
      default:         len = 31;
    endcase
    yy = year;
    mm = month;
    // january and february count as months 13 and 14 of the year before
    if (mm <= MONTH_FEB) begin
      yy = yy - 1;
      mm = mm + MONTHS_YEAR;
    end
    sum = yy + yy / 4 - yy / 100 + yy / 400 + (13 * mm + 8) / 5 + 1;
    col = sum % 7;
    row = 0;
    for (int unsigned d = 1; d <= len; d++) begin
      one_day.day   = DAY_W'(d);
      one_day.col   = COL_W'(col);
      one_day.row   = ROW_W'(row);
      one_day.tens  = (d >= 10) ? CHAR_W'(ASCII_ZERO + d / 10) : ASCII_SPACE;
      one_day.units = CHAR_W'(ASCII_ZERO + d % 10);
      one_day.last  = (d == len);
      pending_days.push_back(one_day);
      // new row after every saturday
      if (col == COL_SATURDAY) begin
        col = 0;
        row++;
      end else begin
        col++;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    day_errs++;
    if (day_errs <= MAX_PRINTS) begin
      $display("mismatch after %0d day items: %s got %0d want %0d",
               days_checked, what, got, want);
    end
  endtask

  // one year/month item onto the input stream, with a random lead-in gap
  task automatic send_month(input logic [YEAR_W-1:0] year, input logic [MONTH_W-1:0] month);
    int unsigned gap;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
    @(negedge clk_i);
    repeat (gap) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {{(IN_TDATA_W - YEAR_W - MONTH_W){1'b0}}, month, year};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_month(year, month);
    months_sent++;
  endtask

  // stop sending and wait until every predicted day has come out
  task automatic wait_all_days();
    @(negedge clk_i);
    s_valid = 1'b0;
    while (pending_days.size() != 0) @(posedge clk_i);
  endtask

  // sink readiness: hold off for the drawn number of cycles after each item
  always @(negedge clk_i) begin
    if (sink_wait > 0) begin
      m_ready = 1'b0;
      sink_wait--;
    end else begin
      m_ready = 1'b1;
    end
  end

  // day item checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got_cell.day   = m_axis_tdata_o[4:0];
      got_cell.col   = m_axis_tdata_o[7:5];
      got_cell.row   = m_axis_tdata_o[10:8];
      got_cell.tens  = m_axis_tdata_o[16:11];
      got_cell.units = m_axis_tdata_o[22:17];
      got_cell.last  = m_axis_tlast_o;
      sink_wait = (sink_stall_max == 0) ? 0 : $urandom_range(0, sink_stall_max);
      if (pending_days.size() == 0) begin
        report_mismatch("day item with none pending, day", got_cell.day, 0);
      end else begin
        want_cell = pending_days.pop_front();
        if (got_cell.day != want_cell.day)
          report_mismatch("day_number", got_cell.day, want_cell.day);
        if (got_cell.col != want_cell.col)
          report_mismatch("column", got_cell.col, want_cell.col);
        if (got_cell.row != want_cell.row)
          report_mismatch("row", got_cell.row, want_cell.row);
        if (got_cell.tens != want_cell.tens)
          report_mismatch("tens_char", got_cell.tens, want_cell.tens);
        if (got_cell.units != want_cell.units)
          report_mismatch("units_char", got_cell.units, want_cell.units);
        if (got_cell.last != want_cell.last)
          report_mismatch("tlast", got_cell.last, want_cell.last);
        days_checked++;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d days pending",
                 idle_cycles, pending_days.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // range ends, leap rules, six-row month, every month, out-of-range inputs
  task automatic test_directed();
    src_gap_max    = 3;
    sink_stall_max = 3;
    send_month(YEAR_W'(1), 4'd1);
    send_month(YEAR_W'(1), 4'd2);
    send_month(YEAR_MAX, 4'd12);
    send_month(YEAR_MAX, 4'd2);
    send_month(YEAR_W'(2000), 4'd2);
    send_month(YEAR_W'(1900), 4'd2);
    send_month(YEAR_W'(2023), 4'd2);
    send_month(YEAR_W'(2022), 4'd10);
    for (int m = 1; m <= 12; m++) send_month(YEAR_W'(2024), MONTH_W'(m));
    send_month(YEAR_W'(0), 4'd5);
    send_month(YEAR_W'(10000), 4'd7);
    send_month(YEAR_W'(16383), 4'd15);
    send_month(YEAR_W'(2024), 4'd0);
    send_month(YEAR_W'(2024), 4'd13);
  endtask

  // sender holds off until the block has drained
  task automatic test_drain_pause();
    src_gap_max    = 0;
    sink_stall_max = 15;
    send_month(YEAR_W'(1600), 4'd3);
    send_month(YEAR_W'(5), 4'd14);
    send_month(YEAR_W'(8191), 4'd8);
    wait_all_days();
    send_month(YEAR_W'(2100), 4'd2);
    send_month(YEAR_W'(400), 4'd1);
  endtask

  // random months, biased to leap boundaries, with some raw noise items
  task automatic test_random_months();
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    int unsigned        pick;
    for (int i = 0; i < RANDOM_MONTHS; i++) begin
      // change the idling mix every few dozen items
      if (i % 40 == 0) begin
        case ((i / 40) % 5)
          0: begin src_gap_max = 15; sink_stall_max = 15; end
          1: begin src_gap_max = 0;  sink_stall_max = 0;  end
          2: begin src_gap_max = 15; sink_stall_max = 0;  end
          3: begin src_gap_max = 0;  sink_stall_max = 15; end
          default: begin src_gap_max = 4; sink_stall_max = 2; end
        endcase
      end
      pick  = $urandom_range(0, 15);
      month = MONTH_W'($urandom_range(1, 12));
      case (pick)
        0, 1: year = YEAR_W'($urandom_range(0, 16383));
        2:    year = YEAR_W'($urandom_range(1, 24) * 400);
        3:    year = YEAR_W'($urandom_range(1, 99) * 100);
        4, 5: year = YEAR_W'($urandom_range(1, 2499) * 4);
        default: year = YEAR_W'($urandom_range(1, 9999));
      endcase
      if (pick == 0) month = MONTH_W'($urandom_range(0, 15));
      if (pick >= 2 && pick <= 5 && $urandom_range(0, 1) == 1) month = MONTH_FEB;
      send_month(year, month);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_drain_pause();
    test_random_months();

    wait_all_days();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d year/month items, %0d of them out of range",
             months_sent, months_void);
    $display("checked %0d day items, %0d mismatches, %0d still pending",
             days_checked, day_errs, pending_days.size());
    if (day_errs == 0 && pending_days.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
